// ===== design/fbt_pkg.sv =====
// shared types, constants and helpers for the thumbnail downscaler
`timescale 1ns / 1ps

package fbt_pkg;

    localparam int THUMB_WIDTH   = 85;
    localparam int THUMB_HEIGHT  = 115;
    localparam int MAX_DIMENSION = 2048;
    localparam int FRAC_BITS     = 16;

    localparam int CFG_W    = 12;               // config register width
    localparam int SRC_W    = 11;               // source column / row counter
    localparam int DIM_W    = 7;                // thumbnail coordinate and size
    localparam int SCALE_W  = 22;               // 6.16 scale
    localparam int SAMPLE_W = 28;               // 12.16 sample position
    localparam int DIV_W    = CFG_W + FRAC_BITS; // dividend and quotient width
    localparam int DIV_STEPS = DIV_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int IDX_W    = 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0]   WIDTH_RESET  = CFG_W'(85);
    localparam logic [CFG_W-1:0]   HEIGHT_RESET = CFG_W'(115);
    localparam logic [CFG_W-1:0]   MAX_DIM      = CFG_W'(MAX_DIMENSION);
    localparam logic [DIM_W-1:0]   THUMB_W_DIM  = DIM_W'(THUMB_WIDTH);
    localparam logic [DIM_W-1:0]   THUMB_H_DIM  = DIM_W'(THUMB_HEIGHT);
    localparam logic [SCALE_W-1:0] ONE_FIXED    = SCALE_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SX_GO,
        SEQ_SX_WAIT,
        SEQ_CAND_GO,
        SEQ_CAND_WAIT,
        SEQ_HOLD_GO,
        SEQ_HOLD_WAIT
    } seq_state_t;

    // scale unit to front end
    typedef struct packed {
        logic               busy;
        logic               load_hold;
        logic [CFG_W-1:0]   w_eff;
        logic [CFG_W-1:0]   h_eff;
        logic [SCALE_W-1:0] scale_cand;
        logic [DIM_W-1:0]   ow_cand;
        logic [DIM_W-1:0]   oh_cand;
        logic [DIM_W-1:0]   ow_hold;
        logic [DIM_W-1:0]   oh_hold;
    } scale_info_t;

    // one sampled pixel waiting for the back end
    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [DIM_W-1:0] out_column;
        logic [DIM_W-1:0] out_row;
        logic [DIM_W-1:0] out_width;
        logic [DIM_W-1:0] out_height;
        logic             last_pixel;
    } entry_t;

    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > MAX_DIM) begin
            r = MAX_DIM;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIV_W-1:0] q,
                                                   input logic [DIM_W-1:0] cap);
        logic [DIM_W-1:0] r;
        if (q > DIV_W'(cap)) begin
            r = cap;
        end else if (q == '0) begin
            r = DIM_W'(1);
        end else begin
            r = q[DIM_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/fbt_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module fbt_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [fbt_pkg::DIV_W-1:0]     dividend,
    input  logic [fbt_pkg::SCALE_W-1:0]   divisor,
    output logic                          done,
    output logic [fbt_pkg::DIV_W-1:0]     quotient
);

    logic                            run_reg;
    logic                            done_reg;
    logic [fbt_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [fbt_pkg::DIV_W-1:0]       dvd_reg;
    logic [fbt_pkg::SCALE_W-1:0]     rem_reg;
    logic [fbt_pkg::SCALE_W-1:0]     dsr_reg;

    logic [fbt_pkg::SCALE_W:0]       trial;
    logic                            fits;
    logic [fbt_pkg::SCALE_W:0]       diff;
    logic [fbt_pkg::SCALE_W-1:0]     rem_next;

    always_comb begin
        trial    = {rem_reg, dvd_reg[fbt_pkg::DIV_W-1]};
        fits     = trial >= {1'b0, dsr_reg};
        diff     = trial - {1'b0, dsr_reg};
        // remainder stays below the divisor, so the top bit is dropped safely
        rem_next = fits ? diff[fbt_pkg::SCALE_W-1:0] : trial[fbt_pkg::SCALE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (run_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == fbt_pkg::DIV_CNT_W'(fbt_pkg::DIV_STEPS - 1)) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (run_reg) begin
            dvd_reg <= {dvd_reg[fbt_pkg::DIV_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== design/fbt_scale.sv =====
// config registers and the scale / thumbnail size sequencer
`timescale 1ns / 1ps

module fbt_scale (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fbt_pkg::IDX_W-1:0]     cfg_index,
    input  logic [fbt_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [fbt_pkg::SCALE_W-1:0]   scale_hold,
    output fbt_pkg::scale_info_t          info
);

    logic                        cfg_wr;
    logic [fbt_pkg::CFG_W-1:0]   width_reg;
    logic [fbt_pkg::CFG_W-1:0]   height_reg;
    logic [fbt_pkg::CFG_W-1:0]   w_eff;
    logic [fbt_pkg::CFG_W-1:0]   h_eff;

    fbt_pkg::seq_state_t         state_reg;
    fbt_pkg::seq_state_t         state_next;

    logic                        start;
    logic [fbt_pkg::SCALE_W-1:0] div_w_dsr;
    logic [fbt_pkg::SCALE_W-1:0] div_h_dsr;
    logic [fbt_pkg::DIV_W-1:0]   w_dvd;
    logic [fbt_pkg::DIV_W-1:0]   h_dvd;
    logic                        done_w;
    logic                        done_h;
    logic [fbt_pkg::DIV_W-1:0]   q_w;
    logic [fbt_pkg::DIV_W-1:0]   q_h;
    logic                        pass_done;

    logic [fbt_pkg::SCALE_W-1:0] sx;
    logic [fbt_pkg::SCALE_W-1:0] sy;
    logic [fbt_pkg::SCALE_W-1:0] s_max;
    logic [fbt_pkg::SCALE_W-1:0] scale_cand_reg;
    logic [fbt_pkg::DIM_W-1:0]   ow_cand_reg;
    logic [fbt_pkg::DIM_W-1:0]   oh_cand_reg;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= fbt_pkg::WIDTH_RESET;
            height_reg <= fbt_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                fbt_pkg::REG_SOURCE_WIDTH:  width_reg  <= cfg_wdata;
                fbt_pkg::REG_SOURCE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_eff = fbt_pkg::eff_size(width_reg);
    assign h_eff = fbt_pkg::eff_size(height_reg);
    assign w_dvd = {w_eff, fbt_pkg::FRAC_BITS'(0)};
    assign h_dvd = {h_eff, fbt_pkg::FRAC_BITS'(0)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fbt_pkg::SEQ_SX_GO;
        end else begin
            state_reg <= state_next;
        end
    end

    assign pass_done = done_w && done_h;

    // three passes: raw scale, sizes under the new scale, sizes under the held scale
    always_comb begin
        state_next = state_reg;
        start      = 1'b0;
        div_w_dsr  = fbt_pkg::SCALE_W'(fbt_pkg::THUMB_WIDTH);
        div_h_dsr  = fbt_pkg::SCALE_W'(fbt_pkg::THUMB_HEIGHT);
        unique case (state_reg)
            fbt_pkg::SEQ_IDLE: ;
            fbt_pkg::SEQ_SX_GO: begin
                start      = 1'b1;
                state_next = fbt_pkg::SEQ_SX_WAIT;
            end
            fbt_pkg::SEQ_SX_WAIT: begin
                if (pass_done) state_next = fbt_pkg::SEQ_CAND_GO;
            end
            fbt_pkg::SEQ_CAND_GO: begin
                start      = 1'b1;
                div_w_dsr  = scale_cand_reg;
                div_h_dsr  = scale_cand_reg;
                state_next = fbt_pkg::SEQ_CAND_WAIT;
            end
            fbt_pkg::SEQ_CAND_WAIT: begin
                if (pass_done) state_next = fbt_pkg::SEQ_HOLD_GO;
            end
            fbt_pkg::SEQ_HOLD_GO: begin
                start      = 1'b1;
                div_w_dsr  = scale_hold;
                div_h_dsr  = scale_hold;
                state_next = fbt_pkg::SEQ_HOLD_WAIT;
            end
            fbt_pkg::SEQ_HOLD_WAIT: begin
                if (pass_done) state_next = fbt_pkg::SEQ_IDLE;
            end
            default: state_next = fbt_pkg::SEQ_SX_GO;
        endcase
        // a new size restarts the whole sequence
        if (cfg_wr) state_next = fbt_pkg::SEQ_SX_GO;
    end

    fbt_div u_div_w (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .dividend (w_dvd),
        .divisor  (div_w_dsr),
        .done     (done_w),
        .quotient (q_w)
    );

    fbt_div u_div_h (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .dividend (h_dvd),
        .divisor  (div_h_dsr),
        .done     (done_h),
        .quotient (q_h)
    );

    always_comb begin
        sx    = q_w[fbt_pkg::SCALE_W-1:0];
        sy    = q_h[fbt_pkg::SCALE_W-1:0];
        s_max = (sx > sy) ? sx : sy;
        if (s_max < fbt_pkg::ONE_FIXED) s_max = fbt_pkg::ONE_FIXED;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == fbt_pkg::SEQ_SX_WAIT && pass_done) begin
            scale_cand_reg <= s_max;
        end
        if (state_reg == fbt_pkg::SEQ_CAND_WAIT && pass_done) begin
            ow_cand_reg <= fbt_pkg::clamp_dim(q_w, fbt_pkg::THUMB_W_DIM);
            oh_cand_reg <= fbt_pkg::clamp_dim(q_h, fbt_pkg::THUMB_H_DIM);
        end
    end

    always_comb begin
        info.busy       = (state_reg != fbt_pkg::SEQ_IDLE);
        info.load_hold  = (state_reg == fbt_pkg::SEQ_HOLD_WAIT) && pass_done && !cfg_wr;
        info.w_eff      = w_eff;
        info.h_eff      = h_eff;
        info.scale_cand = scale_cand_reg;
        info.ow_cand    = ow_cand_reg;
        info.oh_cand    = oh_cand_reg;
        info.ow_hold    = fbt_pkg::clamp_dim(q_w, fbt_pkg::THUMB_W_DIM);
        info.oh_hold    = fbt_pkg::clamp_dim(q_h, fbt_pkg::THUMB_H_DIM);
    end

endmodule

// ===== design/fbt_front.sv =====
// front end: raster counters and the sample decision for each source pixel
`timescale 1ns / 1ps

module fbt_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,
    input  fbt_pkg::scale_info_t          info,
    input  logic                          q_full,
    output logic [fbt_pkg::SCALE_W-1:0]   scale_hold,
    output logic                          push,
    output fbt_pkg::entry_t               push_entry
);

    logic [fbt_pkg::SRC_W-1:0]    src_col_reg;
    logic [fbt_pkg::SRC_W-1:0]    src_row_reg;
    logic [fbt_pkg::SCALE_W-1:0]  scale_reg;
    logic [fbt_pkg::DIM_W-1:0]    ow_reg;
    logic [fbt_pkg::DIM_W-1:0]    oh_reg;
    logic [fbt_pkg::SAMPLE_W-1:0] nsc_reg;
    logic [fbt_pkg::SAMPLE_W-1:0] nsr_reg;
    logic [fbt_pkg::DIM_W-1:0]    th_col_reg;
    logic [fbt_pkg::DIM_W-1:0]    th_row_reg;

    logic                         accept;
    logic                         frame_start;
    logic [fbt_pkg::SCALE_W-1:0]  scale_e;
    logic [fbt_pkg::DIM_W-1:0]    ow_e;
    logic [fbt_pkg::DIM_W-1:0]    oh_e;
    logic                         row_hit;
    logic                         emit;
    logic                         col_wrap;
    logic                         row_wrap;
    logic [fbt_pkg::CFG_W-1:0]    col_inc;
    logic [fbt_pkg::CFG_W-1:0]    row_inc;
    logic [fbt_pkg::DIM_W:0]      th_col_inc;
    logic [fbt_pkg::DIM_W:0]      th_row_inc;

    assign s_tready = !info.busy && !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        frame_start = (src_col_reg == '0) && (src_row_reg == '0);
        // the first pixel of a frame already sees the scale latched from the registers
        scale_e     = frame_start ? info.scale_cand : scale_reg;
        ow_e        = frame_start ? info.ow_cand : ow_reg;
        oh_e        = frame_start ? info.oh_cand : oh_reg;
        row_hit     = (th_row_reg < oh_e) &&
                      ({1'b0, src_row_reg} == nsr_reg[fbt_pkg::SAMPLE_W-1:fbt_pkg::FRAC_BITS]);
        emit        = row_hit && (th_col_reg < ow_e) &&
                      ({1'b0, src_col_reg} == nsc_reg[fbt_pkg::SAMPLE_W-1:fbt_pkg::FRAC_BITS]);
        col_inc     = {1'b0, src_col_reg} + 1'b1;
        row_inc     = {1'b0, src_row_reg} + 1'b1;
        col_wrap    = col_inc >= info.w_eff;
        row_wrap    = row_inc >= info.h_eff;
        th_col_inc  = {1'b0, th_col_reg} + 1'b1;
        th_row_inc  = {1'b0, th_row_reg} + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            nsc_reg     <= '0;
            nsr_reg     <= '0;
            th_col_reg  <= '0;
            th_row_reg  <= '0;
            scale_reg   <= fbt_pkg::ONE_FIXED;
        end else if (accept) begin
            if (frame_start) scale_reg <= info.scale_cand;
            if (emit) begin
                th_col_reg <= th_col_inc[fbt_pkg::DIM_W-1:0];
                nsc_reg    <= nsc_reg + fbt_pkg::SAMPLE_W'(scale_e);
            end
            if (col_wrap) begin
                src_col_reg <= '0;
                th_col_reg  <= '0;
                nsc_reg     <= '0;
                if (row_hit) begin
                    th_row_reg <= th_row_inc[fbt_pkg::DIM_W-1:0];
                    nsr_reg    <= nsr_reg + fbt_pkg::SAMPLE_W'(scale_e);
                end
                if (row_wrap) begin
                    src_row_reg <= '0;
                    th_row_reg  <= '0;
                    nsr_reg     <= '0;
                end else begin
                    src_row_reg <= row_inc[fbt_pkg::SRC_W-1:0];
                end
            end else begin
                src_col_reg <= col_inc[fbt_pkg::SRC_W-1:0];
            end
        end
    end

    // sizes follow the held scale after a mid-frame size change
    always_ff @(posedge aclk) begin
        if (info.load_hold) begin
            ow_reg <= info.ow_hold;
            oh_reg <= info.oh_hold;
        end else if (accept && frame_start) begin
            ow_reg <= info.ow_cand;
            oh_reg <= info.oh_cand;
        end
    end

    assign scale_hold = scale_reg;
    assign push       = accept && emit;

    always_comb begin
        push_entry.red        = s_tdata[7:0];
        push_entry.green      = s_tdata[15:8];
        push_entry.blue       = s_tdata[23:16];
        push_entry.out_column = th_col_reg;
        push_entry.out_row    = th_row_reg;
        push_entry.out_width  = ow_e;
        push_entry.out_height = oh_e;
        push_entry.last_pixel = (th_col_inc == {1'b0, ow_e}) && (th_row_inc == {1'b0, oh_e});
    end

endmodule

// ===== design/fbt_queue.sv =====
// small fifo between the sample decision and the output stage
`timescale 1ns / 1ps

module fbt_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  fbt_pkg::entry_t  push_entry,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output fbt_pkg::entry_t  head
);

    fbt_pkg::entry_t                   mem_reg [fbt_pkg::QUEUE_DEPTH];
    logic [fbt_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [fbt_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [fbt_pkg::QUEUE_PTR_W:0]     count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            priority if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign full      = (count_reg == (fbt_pkg::QUEUE_PTR_W + 1)'(fbt_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

endmodule

// ===== design/fbt_back.sv =====
// back end: rgb565 packing and the output register
`timescale 1ns / 1ps

module fbt_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_not_empty,
    input  fbt_pkg::entry_t  head,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,
    output logic             m_tlast
);

    logic                        valid_reg;
    logic [15:0]                 pixel_reg;
    logic [fbt_pkg::DIM_W-1:0]   col_reg;
    logic [fbt_pkg::DIM_W-1:0]   row_reg;
    logic [fbt_pkg::DIM_W-1:0]   width_reg;
    logic [fbt_pkg::DIM_W-1:0]   height_reg;
    logic                        last_reg;
    logic [15:0]                 pixel_next;

    assign pop        = q_not_empty && (!valid_reg || m_tready);
    assign pixel_next = {head.red[7:3], head.green[7:2], head.blue[7:3]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_tready) begin
            valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            pixel_reg  <= pixel_next;
            col_reg    <= head.out_column;
            row_reg    <= head.out_row;
            width_reg  <= head.out_width;
            height_reg <= head.out_height;
            last_reg   <= head.last_pixel;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0, height_reg, width_reg, row_reg, col_reg, pixel_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== design/fit_box_thumbnail_rgb565_core.sv =====
// A sampled pixel passes through the queue and then the output register before it appears on m_tdata.
// Throughput: one source pixel per cycle while the scale unit is idle and the queue is not full;
// the four-entry queue lets output stalls ride out. After reset and after every config write
// the scale unit reruns three divider passes (one quotient bit per cycle) and s_tready stays low meanwhile.
// Reset is synchronous on aresetn low: counters, queue and output valid clear,
// and the size registers return to 85 x 115.
`timescale 1ns / 1ps

module fit_box_thumbnail_rgb565_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // red, green, blue
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [47:0]                 m_tdata,   // pixel_rgb565, out_column, out_row,
                                                   // out_width, out_height, zero pad
    output logic                        m_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fbt_pkg::IDX_W-1:0]   cfg_index,
    input  logic [fbt_pkg::CFG_W-1:0]   cfg_wdata
);

    fbt_pkg::scale_info_t          info;
    logic [fbt_pkg::SCALE_W-1:0]   scale_hold;
    logic                          push;
    fbt_pkg::entry_t               push_entry;
    logic                          pop;
    logic                          q_full;
    logic                          q_not_empty;
    fbt_pkg::entry_t               head;

    fbt_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .scale_hold (scale_hold),
        .info       (info)
    );

    fbt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .info       (info),
        .q_full     (q_full),
        .scale_hold (scale_hold),
        .push       (push),
        .push_entry (push_entry)
    );

    fbt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    fbt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== design/fbt_checker.sv =====
// port-level checks for the thumbnail downscaler, bound to the top level
`timescale 1ns / 1ps

module fbt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // coordinates stay inside the thumbnail size they carry
    a_in_box: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[22:16] < m_tdata[36:30]) && (m_tdata[29:23] < m_tdata[43:37]))
        else $error("thumbnail coordinate out of range");

    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |->
            (m_tdata[22:16] + 7'd1 == m_tdata[36:30]) && (m_tdata[29:23] + 7'd1 == m_tdata[43:37]))
        else $error("last flag away from the bottom-right pixel");

    // a size change stalls input until the scale is recomputed
    a_cfg_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("input taken during scale recompute");

endmodule

bind fit_box_thumbnail_rgb565_core fbt_checker u_fbt_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ===== dv/tb_fit_box_thumbnail_rgb565_core.sv =====
// testbench for the thumbnail downscaler: random frames, idle phases and stalls against a predictor
`timescale 1ns / 1ps

module tb_fit_box_thumbnail_rgb565_core;
    import fbt_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [15:0]      rgb565;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] wid;
        logic [DIM_W-1:0] hgt;
        logic             last_flag;
    } thumb_px_t;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata   = '0;   // red, green, blue
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [47:0]       m_tdata;          // pixel_rgb565, out_column, out_row,
                                         // out_width, out_height, zero pad
    logic              m_tlast;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = REG_SOURCE_WIDTH;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // predictor state
    logic [CFG_W-1:0]    cfg_width_reg  = WIDTH_RESET;
    logic [CFG_W-1:0]    cfg_height_reg = HEIGHT_RESET;
    logic [SRC_W-1:0]    src_col        = '0;
    logic [SRC_W-1:0]    src_row        = '0;
    logic [SCALE_W-1:0]  latched_scale  = ONE_FIXED;
    logic [SAMPLE_W-1:0] col_target     = '0;
    logic [SAMPLE_W-1:0] row_target     = '0;
    logic [DIM_W-1:0]    th_col         = '0;
    logic [DIM_W-1:0]    th_row         = '0;

    thumb_px_t   pending_thumb_px[$];
    int unsigned src_idle_pct  = 6;
    int unsigned sink_idle_pct = 49;
    int          sink_hold_len = 0;
    int          quiet_cycles  = 0;
    int          mismatches    = 0;
    int          pixels_sent   = 0;
    int          pixels_checked = 0;
    int          frame_ends    = 0;
    int          reg_writes    = 0;

    fit_box_thumbnail_rgb565_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned clip_size(input logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIMENSION) return MAX_DIMENSION;
        return v;
    endfunction

    function void refresh_scale();
        longint unsigned sx, sy;
        sx = clip_size(cfg_width_reg);
        sy = clip_size(cfg_height_reg);
        sx = (sx << FRAC_BITS) / THUMB_WIDTH;
        sy = (sy << FRAC_BITS) / THUMB_HEIGHT;
        if (sy > sx) sx = sy;
        if (sx < (64'd1 << FRAC_BITS)) sx = 64'd1 << FRAC_BITS;
        latched_scale = sx[SCALE_W-1:0];
    endfunction

    function automatic int unsigned thumb_extent(input int unsigned size, input int unsigned cap);
        longint unsigned d;
        d = size;
        d = (d << FRAC_BITS) / latched_scale;
        if (d > cap) d = cap;
        if (d < 1) d = 1;
        return d;
    endfunction

    // advance the source position by one pixel and queue the thumbnail pixel it yields
    function void predict_thumb_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
        int unsigned w, h, ow, oh;
        bit          row_hit;
        thumb_px_t   px;
        if (src_col == '0 && src_row == '0) refresh_scale();
        w  = clip_size(cfg_width_reg);
        h  = clip_size(cfg_height_reg);
        ow = thumb_extent(w, THUMB_WIDTH);
        oh = thumb_extent(h, THUMB_HEIGHT);
        row_hit = (th_row < oh) && (src_row == row_target[SAMPLE_W-1:FRAC_BITS]);
        if (row_hit && th_col < ow && src_col == col_target[SAMPLE_W-1:FRAC_BITS]) begin
            px.rgb565    = {r[7:3], g[7:2], b[7:3]};
            px.col       = th_col;
            px.row       = th_row;
            px.wid       = ow[DIM_W-1:0];
            px.hgt       = oh[DIM_W-1:0];
            px.last_flag = (th_col + 1 == ow) && (th_row + 1 == oh);
            pending_thumb_px.push_back(px);
            th_col     = th_col + 1'b1;
            col_target = col_target + latched_scale;
        end
        if (src_col + 1 >= w) begin
            src_col    = '0;
            th_col     = '0;
            col_target = '0;
            if (row_hit) begin
                th_row     = th_row + 1'b1;
                row_target = row_target + latched_scale;
            end
            if (src_row + 1 >= h) begin
                src_row    = '0;
                th_row     = '0;
                row_target = '0;
            end else begin
                src_row = src_row + 1'b1;
            end
        end else begin
            src_col = src_col + 1'b1;
        end
    endfunction

    function void check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        thumb_px_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_thumb_px.size() == 0) begin
                $display("%0t: unexpected thumbnail pixel, expected none, actual %h", $time,
                         m_tdata);
                mismatches++;
            end else begin
                want = pending_thumb_px.pop_front();
                check_field("pixel_rgb565", want.rgb565, m_tdata[15:0]);
                check_field("out_column",   want.col,    m_tdata[22:16]);
                check_field("out_row",      want.row,    m_tdata[29:23]);
                check_field("out_width",    want.wid,    m_tdata[36:30]);
                check_field("out_height",   want.hgt,    m_tdata[43:37]);
                check_field("last_pixel",   want.last_flag, m_tlast);
                pixels_checked++;
                if (want.last_flag) frame_ends++;
            end
        end
    end

    // receiver: random idling plus a long hold-off on demand
    always @(negedge aclk) begin
        if (sink_hold_len > 0) begin
            m_tready      <= 1'b0;
            sink_hold_len <= sink_hold_len - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_thumb_px.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_pixel(input logic [23:0] rgb);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rgb;
        do @(posedge aclk); while (!s_tready);
        predict_thumb_pixel(rgb[7:0], rgb[15:8], rgb[23:16]);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic send_burst(input int n);
        if (n > 0) begin
            repeat (n) send_pixel($urandom);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_quiet();
        while (pending_thumb_px.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_sizes(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= REG_SOURCE_WIDTH;
        cfg_wdata <= w;
        do @(posedge aclk); while (!cfg_ready);
        cfg_width_reg = w;
        @(negedge aclk);
        cfg_index <= REG_SOURCE_HEIGHT;
        cfg_wdata <= h;
        do @(posedge aclk); while (!cfg_ready);
        cfg_height_reg = h;
        reg_writes += 2;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // color extremes at reset size, a width cut mid-row, then one-pixel frames
    task automatic test_directed_pixels();
        logic [23:0] colors[12] = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
                                    24'hFF0000, 24'h070307, 24'hF8FCF8, 24'h080408,
                                    24'h5A5A5A, 24'hA5A5A5, 24'h123456, 24'hFEDCBA};
        foreach (colors[i]) send_pixel(colors[i]);
        s_tvalid <= 1'b0;
        wait_quiet();
        // column already past the new width wraps on the next pixel
        write_sizes(12'd4, 12'd115);
        send_burst(4);
        wait_quiet();
        // zero sizes count as one
        write_sizes(12'd0, 12'd0);
        send_burst(5);
        wait_quiet();
    endtask

    // reach the last thumbnail column and row
    task automatic test_full_span();
        write_sizes(THUMB_WIDTH, 12'd1);
        send_burst(THUMB_WIDTH);
        wait_quiet();
        write_sizes(12'd1, THUMB_HEIGHT);
        send_burst(THUMB_HEIGHT);
        wait_quiet();
    endtask

    // oversize and maximum sizes as partial frames with writes mid-frame, then a full 5 x 2 frame and more
    task automatic test_large_sizes();
        write_sizes(12'hFFF, 12'd3);
        send_burst(150);
        wait_quiet();
        write_sizes(12'd1, 12'hFFF);
        send_burst(40);
        wait_quiet();
        write_sizes(MAX_DIM, MAX_DIM);
        send_burst(20);
        wait_quiet();
        write_sizes(12'd5, 12'd2);
        send_burst(12);
        wait_quiet();
    endtask

    // output held off long enough to fill the block while pixels keep coming
    task automatic test_output_stall();
        src_idle_pct = 0;
        write_sizes(12'd40, 12'd4);
        @(posedge aclk);
        sink_hold_len = HOLD_CYCLES;
        @(negedge aclk);
        send_burst(160);
        wait_quiet();
        src_idle_pct = 6;
    endtask

    task automatic run_random_frames(input int target, input int src_pct, input int sink_pct);
        int          sent_here;
        int unsigned w, h, n, half;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent_here     = 0;
        while (sent_here < target) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    w = $urandom_range(1, 24);
                    h = $urandom_range(1, 24);
                end
                4: begin
                    w = $urandom_range(1, 3);
                    h = $urandom_range(116, 200);
                end
                5: begin
                    w = $urandom_range(86, 180);
                    h = $urandom_range(1, 3);
                end
                6: begin
                    w = $urandom_range(1, 6);
                    h = $urandom_range(1, 6);
                end
                7: begin
                    w = ($urandom_range(1) == 0) ? 0 : $urandom_range(2049, 4095);
                    h = $urandom_range(0, 6);
                end
                8: begin
                    w = $urandom_range(1, 6);
                    h = $urandom_range(2049, 4095);
                end
                default: begin
                    w = $urandom_range(1, 40);
                    h = $urandom_range(1, 40);
                end
            endcase
            wait_quiet();
            write_sizes(w[CFG_W-1:0], h[CFG_W-1:0]);
            n = clip_size(w[CFG_W-1:0]) * clip_size(h[CFG_W-1:0]);
            // broken frame: stop part way, the next write lands mid-frame
            if (n > 1 && (n > 600 || $urandom_range(7) == 0))
                n = $urandom_range(1, (n - 1 > 300) ? 300 : n - 1);
            if ($urandom_range(5) == 0) begin
                half = n / 2;
                send_burst(half);
                wait_quiet();
                send_burst(n - half);
            end else begin
                send_burst(n);
            end
            sent_here += n;
        end
    endtask

    initial begin
        refresh_scale();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_pixels();
        test_full_span();
        test_large_sizes();
        test_output_stall();
        run_random_frames(230, 6, 49);
        run_random_frames(230, 49, 6);
        run_random_frames(230, 0, 0);
        while (pending_thumb_px.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("sent %0d source pixels over %0d register writes", pixels_sent, reg_writes);
        $display("checked %0d thumbnail pixels, %0d frame ends, %0d mismatches",
                 pixels_checked, frame_ends, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
